@@ src/lik_pkg.sv @@
// Shared constants, types and the CORDIC angle table of the leg inverse
// kinematics unit. Depends on nothing; every other file but lik_isqrt imports it.
`default_nettype none

package lik_pkg;

  localparam int COORD_W           = 16;
  localparam int LEN_W             = 14;
  localparam int OFS_W             = 12;
  localparam int ANG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int ANGLE_FRAC_BITS   = 6;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QBITS             = 16;
  localparam int AQ_W              = 26;
  localparam int SUM_W             = AQ_W + 1;
  localparam int MAG_W             = 31;
  localparam int NORM_W            = 30;
  localparam int POS_W             = $clog2(MAG_W);
  localparam int CW                = 33;
  localparam int NW                = 34;
  localparam int DW                = 31;

  localparam logic signed [AQ_W-1:0] Q180 = AQ_W'(180 << QBITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COXA_LEN  = 3'd0,
    REG_FEMUR_LEN = 3'd1,
    REG_TIBIA_LEN = 3'd2,
    REG_COXA_OFS  = 3'd3,
    REG_FEMUR_OFS = 3'd4,
    REG_TIBIA_OFS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               xneg;
    logic               yneg;
    logic               zneg;
    logic [COORD_W-1:0] ux;
    logic [COORD_W-1:0] uy;
    logic [COORD_W-1:0] uz;
  } front_t;

  typedef struct packed {
    front_t             f;
    logic               r2neg;
    logic [COORD_W-1:0] ur2;
  } mid_t;

  typedef struct packed {
    logic [DW-1:0] s;
    logic [DW-1:0] un;
    logic          neg;
    logic          flag;
    logic          special;
  } acos_res_t;

  function automatic logic [AQ_W-1:0] atan_entry(input int k);
    logic [23:0] v;
    unique case (k)
      0:       v = 24'd2949120;
      1:       v = 24'd1740967;
      2:       v = 24'd919879;
      3:       v = 24'd466945;
      4:       v = 24'd234379;
      5:       v = 24'd117304;
      6:       v = 24'd58666;
      7:       v = 24'd29335;
      8:       v = 24'd14668;
      9:       v = 24'd7334;
      10:      v = 24'd3667;
      11:      v = 24'd1833;
      12:      v = 24'd917;
      13:      v = 24'd458;
      14:      v = 24'd229;
      15:      v = 24'd115;
      16:      v = 24'd57;
      17:      v = 24'd29;
      18:      v = 24'd14;
      19:      v = 24'd7;
      20:      v = 24'd4;
      21:      v = 24'd2;
      22:      v = 24'd1;
      default: v = 24'd0;
    endcase
    return AQ_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ src/leg_inverse_kinematics_3dof_unit.sv @@
// Top level of the three-joint leg inverse kinematics unit: configuration
// registers, reach and law-of-cosines datapath, output stage.
// Uses lik_pkg, lik_isqrt, lik_acos and lik_cordic.
//
// Usage:
//   Input channel in_valid/in_stall carries target_x/y/z (1/16 mm); a
//   transfer completes on a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries coxa/femur/tibia angles in
//   1/64 degree and the unreachable flag.
//   Link lengths and trims are written through cfg_wr_en/cfg_index/cfg_data
//   while the unit is idle; there is no read-back.
//   One target per cycle is sustained while the output is not stalled. The
//   pipeline depth comes from three square-root pipelines of one bit per
//   stage and the CORDIC stage chain.
//   A target at the origin is taken and produces no result.
//   Reset clears the configuration registers to zero and empties the pipeline.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is lost or repeated.
`default_nettype none

module leg_inverse_kinematics_3dof_unit
  import lik_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [LEN_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [COORD_W-1:0] target_x,
  input  wire logic signed [COORD_W-1:0] target_y,
  input  wire logic signed [COORD_W-1:0] target_z,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [ANG_W-1:0]    coxa_angle,
  output logic signed [ANG_W-1:0]    femur_angle,
  output logic signed [ANG_W-1:0]    tibia_angle,
  output logic                       unreachable
);

  localparam int SH = QBITS - ANGLE_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND  = SUM_W'(1 << (SH - 1));
  localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic sp0;
    logic ng0;
    logic sp1;
    logic ng1;
    logic flag;
  } fin_t;

  function automatic logic [ANG_W-1:0] to_out(input logic signed [SUM_W-1:0] q,
                                               input logic signed [SUM_W-1:0] add);
    logic signed [SUM_W-1:0] v;
    v = ((q + RND) >>> SH) + add;
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return v[ANG_W-1:0];
  endfunction

  logic                    en;
  logic [LEN_W-1:0]        coxa_length, femur_length, tibia_length;
  logic signed [OFS_W-1:0] coxa_offset, femur_offset, tibia_offset;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coxa_length  <= '0;
      femur_length <= '0;
      tibia_length <= '0;
      coxa_offset  <= '0;
      femur_offset <= '0;
      tibia_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COXA_LEN:  coxa_length  <= cfg_data;
        REG_FEMUR_LEN: femur_length <= cfg_data;
        REG_TIBIA_LEN: tibia_length <= cfg_data;
        REG_COXA_OFS:  coxa_offset  <= $signed(cfg_data[OFS_W-1:0]);
        REG_FEMUR_OFS: femur_offset <= $signed(cfg_data[OFS_W-1:0]);
        REG_TIBIA_OFS: tibia_offset <= $signed(cfg_data[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // front end: magnitudes, squares, horizontal reach
  logic                       v0, v1, v2;
  logic signed [COORD_W-1:0]  x0, y0, z0;
  logic [COORD_W-1:0]         ax, ay, az;
  front_t                     f1, f2, fa;
  logic [2*COORD_W-1:0]       sx1, sy1, sxy2;
  logic                       va;
  logic [COORD_W-1:0]         r1;

  assign ax = x0[COORD_W-1] ? $unsigned(-x0) : $unsigned(x0);
  assign ay = y0[COORD_W-1] ? $unsigned(-y0) : $unsigned(y0);
  assign az = z0[COORD_W-1] ? $unsigned(-z0) : $unsigned(z0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid && !((target_x == '0) && (target_y == '0) && (target_z == '0));
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0      <= target_x;
      y0      <= target_y;
      z0      <= target_z;
      f1.xneg <= x0[COORD_W-1];
      f1.yneg <= y0[COORD_W-1];
      f1.zneg <= z0[COORD_W-1];
      f1.ux   <= ax;
      f1.uy   <= ay;
      f1.uz   <= az;
      sx1     <= ax * ax;
      sy1     <= ay * ay;
      f2      <= f1;
      sxy2    <= sx1 + sy1;
    end
  end

  lik_isqrt #(.W(2*COORD_W), .PW($bits(front_t))) u_sqrt_r1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .rad      (sxy2),
    .in_pay   (f2),
    .out_valid(va),
    .root     (r1),
    .out_pay  (fa)
  );

  // reach beyond the coxa and distance to the target
  logic                       v3, v4, v5;
  logic signed [COORD_W:0]    r2;
  mid_t                       m3, m4, m5, mb;
  logic [2*COORD_W-1:0]       ur2sq, uzsq;
  logic [2*COORD_W:0]         s5;
  logic                       vb;
  logic [COORD_W:0]           r3;

  assign r2 = $signed({1'b0, r1}) - $signed({{(COORD_W+1-LEN_W){1'b0}}, coxa_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v3 <= va;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3.f     <= fa;
      m3.r2neg <= r2[COORD_W];
      m3.ur2   <= r2[COORD_W] ? COORD_W'(-r2) : COORD_W'(r2);
      m4       <= m3;
      ur2sq    <= m3.ur2 * m3.ur2;
      uzsq     <= m3.f.uz * m3.f.uz;
      m5       <= m4;
      s5       <= {1'b0, ur2sq} + {1'b0, uzsq};
    end
  end

  lik_isqrt #(.W(2*COORD_W+2), .PW($bits(mid_t))) u_sqrt_r3 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .rad      ({1'b0, s5}),
    .in_pay   (m5),
    .out_valid(vb),
    .root     (r3),
    .out_pay  (mb)
  );

  // law of cosines terms
  logic                     v6, v7;
  mid_t                     m6, m7, mc;
  logic [2*COORD_W-1:0]     aa6;
  logic [2*LEN_W-1:0]       bb6, cc6, bc6;
  logic [COORD_W+LEN_W-1:0] ab6;
  logic signed [NW-1:0]     n0_7, n1_7;
  logic [DW-1:0]            d0_7, d1_7;
  logic                     vc;
  acos_res_t                ac0, ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v6 <= vb;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m6   <= mb;
      aa6  <= r3[COORD_W-1:0] * r3[COORD_W-1:0];
      bb6  <= femur_length * femur_length;
      cc6  <= tibia_length * tibia_length;
      ab6  <= r3[COORD_W-1:0] * femur_length;
      bc6  <= femur_length * tibia_length;
      m7   <= m6;
      n0_7 <= $signed(NW'(aa6)) + $signed(NW'(bb6)) - $signed(NW'(cc6));
      n1_7 <= $signed(NW'(bb6)) + $signed(NW'(cc6)) - $signed(NW'(aa6));
      d0_7 <= DW'({ab6, 1'b0});
      d1_7 <= DW'({bc6, 1'b0});
    end
  end

  lik_acos #(.PW($bits(mid_t))) u_acos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .n0       (n0_7),
    .d0       (d0_7),
    .n1       (n1_7),
    .d1       (d1_7),
    .in_pay   (m7),
    .out_valid(vc),
    .res0     (ac0),
    .res1     (ac1),
    .out_pay  (mc)
  );

  // four angles in parallel
  fin_t                   fin_c, fin_d;
  logic                   vd;
  logic signed [AQ_W-1:0] a_th1, a_ph3, a_ph2, a_th3;

  assign fin_c.sp0  = ac0.special;
  assign fin_c.ng0  = ac0.neg;
  assign fin_c.sp1  = ac1.special;
  assign fin_c.ng1  = ac1.neg;
  assign fin_c.flag = ac0.flag || ac1.flag;

  lik_cordic #(.STAGES(CORDIC_STAGES), .PW($bits(fin_t))) u_cordic_th1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .ux       (MAG_W'(mc.f.ux)),
    .uy       (MAG_W'(mc.f.uy)),
    .xneg     (mc.f.xneg),
    .yneg     (mc.f.yneg),
    .in_pay   (fin_c),
    .out_valid(vd),
    .angle    (a_th1),
    .out_pay  (fin_d)
  );

  lik_cordic #(.STAGES(CORDIC_STAGES), .PW(1)) u_cordic_ph3 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .ux       (MAG_W'(mc.ur2)),
    .uy       (MAG_W'(mc.f.uz)),
    .xneg     (mc.r2neg),
    .yneg     (mc.f.zneg),
    .in_pay   (1'b0),
    .out_valid(),
    .angle    (a_ph3),
    .out_pay  ()
  );

  lik_cordic #(.STAGES(CORDIC_STAGES), .PW(1)) u_cordic_ph2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .ux       (ac0.un),
    .uy       (ac0.s),
    .xneg     (ac0.neg),
    .yneg     (1'b0),
    .in_pay   (1'b0),
    .out_valid(),
    .angle    (a_ph2),
    .out_pay  ()
  );

  lik_cordic #(.STAGES(CORDIC_STAGES), .PW(1)) u_cordic_th3 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .ux       (ac1.un),
    .uy       (ac1.s),
    .xneg     (ac1.neg),
    .yneg     (1'b0),
    .in_pay   (1'b0),
    .out_valid(),
    .angle    (a_th3),
    .out_pay  ()
  );

  // combine, trim, round and saturate
  logic                    vf;
  logic signed [AQ_W-1:0]  ph2, th3;
  logic signed [SUM_W-1:0] th1_f, fem_f, th3_f;
  logic                    unr_f;

  assign ph2 = fin_d.sp0 ? (fin_d.ng0 ? Q180 : '0) : a_ph2;
  assign th3 = fin_d.sp1 ? (fin_d.ng1 ? Q180 : '0) : a_th3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vf        <= vd;
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th1_f       <= SUM_W'(a_th1);
      fem_f       <= SUM_W'(ph2) + SUM_W'(a_ph3);
      th3_f       <= SUM_W'(th3);
      unr_f       <= fin_d.flag;
      coxa_angle  <= to_out(th1_f, SUM_W'(coxa_offset));
      femur_angle <= to_out(fem_f, BIAS + SUM_W'(femur_offset));
      tibia_angle <= to_out(th3_f, SUM_W'(tibia_offset));
      unreachable <= unr_f;
    end
  end

endmodule

`default_nettype wire

@@ src/lik_isqrt.sv @@
// Pipelined floor integer square root, one root bit per stage, with a
// side payload carried alongside. Stand-alone; no package needed.
`default_nettype none

module lik_isqrt #(
  parameter int W  = 32,
  parameter int PW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [W-1:0]    rad,
  input  wire logic [PW-1:0]   in_pay,
  output logic                 out_valid,
  output logic [W/2-1:0]       root,
  output logic [PW-1:0]        out_pay
);

  localparam int HW = W / 2;
  localparam int RW = HW + 3;

  logic          vld  [HW];
  logic [W-1:0]  vr_q [HW];
  logic [RW-1:0] rm_q [HW];
  logic [HW-1:0] rt_q [HW];
  logic [PW-1:0] py_q [HW];

  for (genvar k = 0; k < HW; k++) begin : g_st
    logic          pv;
    logic [W-1:0]  pvr;
    logic [RW-1:0] prm;
    logic [HW-1:0] prt;
    logic [PW-1:0] ppy;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign pvr = rad;
      assign prm = '0;
      assign prt = '0;
      assign ppy = in_pay;
    end else begin : g_next
      assign pv  = vld[k-1];
      assign pvr = vr_q[k-1];
      assign prm = rm_q[k-1];
      assign prt = rt_q[k-1];
      assign ppy = py_q[k-1];
    end

    assign cur   = {prm[RW-3:0], pvr[W-1 -: 2]};
    assign trial = {1'b0, prt, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vr_q[k] <= pvr << 2;
        py_q[k] <= ppy;
        if (cur >= trial) begin
          rm_q[k] <= cur - trial;
          rt_q[k] <= {prt[HW-2:0], 1'b1};
        end else begin
          rm_q[k] <= cur;
          rt_q[k] <= {prt[HW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[HW-1];
  assign root      = rt_q[HW-1];
  assign out_pay   = py_q[HW-1];

endmodule

`default_nettype wire

@@ src/lik_acos.sv @@
// Two-lane arc cosine front end: clamp, squares, difference and square root,
// giving the atan2 operands of each lane. Uses lik_pkg and lik_isqrt.
`default_nettype none

module lik_acos
  import lik_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [NW-1:0] n0,
  input  wire logic [DW-1:0]        d0,
  input  wire logic signed [NW-1:0] n1,
  input  wire logic [DW-1:0]        d1,
  input  wire logic [PW-1:0]        in_pay,
  output logic                      out_valid,
  output acos_res_t                 res0,
  output acos_res_t                 res1,
  output logic [PW-1:0]             out_pay
);

  typedef struct packed {
    logic [DW-1:0] un;
    logic          neg;
    logic          flag;
    logic          special;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] d;
    side_t         sd;
  } pre_t;

  localparam int SW = $bits(side_t);

  function automatic pre_t clamp(input logic signed [NW-1:0] n, input logic [DW-1:0] d);
    pre_t          p;
    logic [NW-1:0] un;
    logic          over;
    un           = n[NW-1] ? NW'(-n) : NW'(n);
    over         = (d == '0) || (un > NW'(d));
    p.d          = d;
    p.sd.neg     = n[NW-1];
    p.sd.flag    = over;
    p.sd.un      = over ? d : un[DW-1:0];
    p.sd.special = over || (un == NW'(d));
    return p;
  endfunction

  logic            v1, v2, v3;
  pre_t            p1_0, p1_1;
  logic [PW-1:0]   pay1, pay2, pay3;
  logic [2*DW-1:0] dd0, uu0, dd1, uu1;
  logic [2*DW-1:0] df0, df1;
  side_t           s2_0, s2_1, s3_0, s3_1;
  logic [PW+SW-1:0] q0_pay;
  logic [SW-1:0]    q1_pay;
  logic [DW-1:0]    rt0, rt1;
  side_t            o0, o1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_0 <= clamp(n0, d0);
      p1_1 <= clamp(n1, d1);
      pay1 <= in_pay;
      dd0  <= p1_0.d * p1_0.d;
      uu0  <= p1_0.sd.un * p1_0.sd.un;
      dd1  <= p1_1.d * p1_1.d;
      uu1  <= p1_1.sd.un * p1_1.sd.un;
      s2_0 <= p1_0.sd;
      s2_1 <= p1_1.sd;
      pay2 <= pay1;
      df0  <= dd0 - uu0;
      df1  <= dd1 - uu1;
      s3_0 <= s2_0;
      s3_1 <= s2_1;
      pay3 <= pay2;
    end
  end

  lik_isqrt #(.W(2*DW), .PW(PW+SW)) u_sqrt0 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .rad      (df0),
    .in_pay   ({pay3, s3_0}),
    .out_valid(out_valid),
    .root     (rt0),
    .out_pay  (q0_pay)
  );

  lik_isqrt #(.W(2*DW), .PW(SW)) u_sqrt1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .rad      (df1),
    .in_pay   (s3_1),
    .out_valid(),
    .root     (rt1),
    .out_pay  (q1_pay)
  );

  assign o0      = q0_pay[SW-1:0];
  assign o1      = q1_pay;
  assign out_pay = q0_pay[PW+SW-1:SW];

  assign res0.s       = rt0;
  assign res0.un      = o0.un;
  assign res0.neg     = o0.neg;
  assign res0.flag    = o0.flag;
  assign res0.special = o0.special;
  assign res1.s       = rt1;
  assign res1.un      = o1.un;
  assign res1.neg     = o1.neg;
  assign res1.flag    = o1.flag;
  assign res1.special = o1.special;

endmodule

`default_nettype wire

@@ src/lik_cordic.sv @@
// Pipelined atan2 on magnitudes with quadrant signs: normalise, CORDIC
// vectoring stages, quadrant map. Uses lik_pkg.
`default_nettype none

module lik_cordic
  import lik_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int PW     = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [MAG_W-1:0] ux,
  input  wire logic [MAG_W-1:0] uy,
  input  wire logic             xneg,
  input  wire logic             yneg,
  input  wire logic [PW-1:0]    in_pay,
  output logic                  out_valid,
  output logic signed [AQ_W-1:0] angle,
  output logic [PW-1:0]         out_pay
);

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } quad_t;

  logic             v_n1, v_n2, v_n3;
  logic [MAG_W-1:0] ux_n1, uy_n1, m_n1, ux_n2, uy_n2;
  logic [NORM_W-1:0] ux_n3, uy_n3;
  quad_t            qd_n1, qd_n2, qd_n3;
  logic [PW-1:0]    py_n1, py_n2, py_n3;
  logic [POS_W-1:0] pos, pos_n2;
  logic [MAG_W-1:0] xs, ys;

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m_n1[i]) pos = POS_W'(i);
    end
  end

  always_comb begin
    if (pos_n2 > POS_W'(NORM_W-1)) begin
      xs = ux_n2 >> (pos_n2 - POS_W'(NORM_W-1));
      ys = uy_n2 >> (pos_n2 - POS_W'(NORM_W-1));
    end else begin
      xs = ux_n2 << (POS_W'(NORM_W-1) - pos_n2);
      ys = uy_n2 << (POS_W'(NORM_W-1) - pos_n2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_n1 <= 1'b0;
      v_n2 <= 1'b0;
      v_n3 <= 1'b0;
    end else if (en) begin
      v_n1 <= in_valid;
      v_n2 <= v_n1;
      v_n3 <= v_n2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_n1      <= ux;
      uy_n1      <= uy;
      m_n1       <= (ux > uy) ? ux : uy;
      qd_n1.xneg <= xneg;
      qd_n1.yneg <= yneg;
      qd_n1.zero <= (ux == '0) && (uy == '0);
      py_n1      <= in_pay;
      ux_n2      <= ux_n1;
      uy_n2      <= uy_n1;
      pos_n2     <= pos;
      qd_n2      <= qd_n1;
      py_n2      <= py_n1;
      ux_n3      <= xs[NORM_W-1:0];
      uy_n3      <= ys[NORM_W-1:0];
      qd_n3      <= qd_n2;
      py_n3      <= py_n2;
    end
  end

  logic                   vld  [STAGES];
  logic signed [CW-1:0]   cx_q [STAGES];
  logic signed [CW-1:0]   cy_q [STAGES];
  logic signed [AQ_W-1:0] a_q  [STAGES];
  quad_t                  qd_q [STAGES];
  logic [PW-1:0]          py_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_st
    logic                   pv;
    logic signed [CW-1:0]   pcx, pcy;
    logic signed [AQ_W-1:0] pa;
    quad_t                  pqd;
    logic [PW-1:0]          ppy;
    logic signed [AQ_W-1:0] da;

    if (k == 0) begin : g_first
      assign pv  = v_n3;
      assign pcx = $signed({{(CW-NORM_W){1'b0}}, ux_n3});
      assign pcy = $signed({{(CW-NORM_W){1'b0}}, uy_n3});
      assign pa  = '0;
      assign pqd = qd_n3;
      assign ppy = py_n3;
    end else begin : g_next
      assign pv  = vld[k-1];
      assign pcx = cx_q[k-1];
      assign pcy = cy_q[k-1];
      assign pa  = a_q[k-1];
      assign pqd = qd_q[k-1];
      assign ppy = py_q[k-1];
    end

    assign da = $signed(atan_entry(k));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd_q[k] <= pqd;
        py_q[k] <= ppy;
        if (!pcy[CW-1]) begin
          cx_q[k] <= pcx + (pcy >>> k);
          cy_q[k] <= pcy - (pcx >>> k);
          a_q[k]  <= pa + da;
        end else begin
          cx_q[k] <= pcx - (pcy >>> k);
          cy_q[k] <= pcy + (pcx >>> k);
          a_q[k]  <= pa - da;
        end
      end
    end
  end

  logic signed [AQ_W-1:0] qa;
  quad_t                  ql;

  assign ql = qd_q[STAGES-1];

  always_comb begin
    qa = a_q[STAGES-1];
    if (ql.xneg) qa = Q180 - qa;
    if (ql.yneg) qa = -qa;
    if (ql.zero) qa = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= qa;
      out_pay <= py_q[STAGES-1];
    end
  end

endmodule

`default_nettype wire
